### hdl/spi_mbs_pkg.sv
// ---------------------------------------------------------------------------
// SPI master byte shifter package
// Register indexes, reset values and the prescaler half-period table.
// ---------------------------------------------------------------------------
package spi_mbs_pkg;

	// Configuration register indexes
	localparam int unsigned CfgIndexWidth = 3;
	typedef logic [CfgIndexWidth-1:0] cfg_index_t;

	localparam cfg_index_t CFG_RATE_SELECT    = 3'd0;
	localparam cfg_index_t CFG_DOUBLE_SPEED   = 3'd1;
	localparam cfg_index_t CFG_CLOCK_POLARITY = 3'd2;
	localparam cfg_index_t CFG_CLOCK_PHASE    = 3'd3;
	localparam cfg_index_t CFG_LSB_FIRST      = 3'd4;

	// Configuration data carries the widest register (rate_select)
	localparam int unsigned CfgDataWidth = 2;
	typedef logic [CfgDataWidth-1:0] cfg_data_t;

	// Field and state widths
	typedef logic [7:0] byte_t;
	typedef logic [1:0] rate_t;
	typedef logic [5:0] prescale_t;
	typedef logic [6:0] half_t;
	typedef logic [4:0] edge_cnt_t;

	localparam rate_t     RATE_RESET  = 2'd3;
	localparam edge_cnt_t LAST_EDGE   = 5'd16;

	// Half SCK period in ticks for each rate choice at normal speed
	localparam half_t HALF_BASE [4] = '{7'd2, 7'd8, 7'd32, 7'd64};

	// Half period after the double-speed setting
	function automatic half_t half_period(input rate_t rate, input logic dbl);
		half_t base;
		base = HALF_BASE[rate];
		return dbl ? (base >> 1) : base;
	endfunction

endpackage

### hdl/spi_master_byte_shifter.sv
// ---------------------------------------------------------------------------
// SPI master byte shifter
// One-byte SPI master (modes 0 to 3, MSB or LSB first) stepped by tick
// requests; each request returns one snapshot of the pins and status.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | start_req, tx_byte, miso
//  out     | out_valid / out_ready| sck, mosi, busy_res, transfer_done, rx_byte
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Each tick request is handled as it is accepted: the transfer state advances at
//  the edge that accepts it and its result sits in the output register the
//  cycle after, so one request per cycle is sustained while results are taken.
//  The output register is one deep; a new request is taken whenever it is
//  empty or being drained in the same cycle.
//  Reset clears the transfer state and loads the register defaults
//  (rate_select 3, others 0); cfg_ready is always high.
//
module spi_master_byte_shifter (
	input  logic                    clk,
	input  logic                    arst_n,
	// tick requests
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    start_req,
	input  logic [7:0]              tx_byte,
	input  logic                    miso,
	// results
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    sck,
	output logic                    mosi,
	output logic                    busy_res,
	output logic                    transfer_done,
	output logic [7:0]              rx_byte,
	// configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  spi_mbs_pkg::cfg_index_t cfg_index,
	input  spi_mbs_pkg::cfg_data_t  cfg_data
);
	import spi_mbs_pkg::*;

	// Configuration registers
	rate_t rate_select_q;
	logic  double_speed_q;
	logic  clock_polarity_q;
	logic  clock_phase_q;
	logic  lsb_first_q;

	// Transfer state
	byte_t     out_shifter_q;
	byte_t     in_shifter_q;
	byte_t     received_byte_q;
	prescale_t prescale_count_q;
	edge_cnt_t edge_count_q;
	logic      active_q;
	logic      clock_level_q;
	logic      done_flag_q;

	// Result register
	logic  out_valid_q;
	logic  sck_q;
	logic  mosi_q;
	logic  busy_q;
	logic  done_q;
	byte_t rx_q;

	// Next-state values
	byte_t     out_shifter_d;
	byte_t     in_shifter_d;
	byte_t     received_byte_d;
	prescale_t prescale_count_d;
	edge_cnt_t edge_count_d;
	logic      active_d;
	logic      clock_level_d;
	logic      done_flag_d;

	logic      in_fire;
	logic      cfg_fire;
	logic      pol_write;
	half_t     half;
	edge_cnt_t edge_next;
	logic      leading;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign pol_write = cfg_fire && (cfg_index == CFG_CLOCK_POLARITY);

	assign half      = half_period(rate_select_q, double_speed_q);
	assign edge_next = edge_count_q + 5'd1;
	assign leading   = edge_next[0];

	// Advance the transfer by one tick
	always_comb begin
		out_shifter_d    = out_shifter_q;
		in_shifter_d     = in_shifter_q;
		received_byte_d  = received_byte_q;
		prescale_count_d = prescale_count_q;
		edge_count_d     = edge_count_q;
		active_d         = active_q;
		clock_level_d    = clock_level_q;
		done_flag_d      = done_flag_q;
		if (in_fire) begin
			if (!active_q) begin
				if (start_req) begin
					out_shifter_d    = tx_byte;
					in_shifter_d     = '0;
					prescale_count_d = '0;
					edge_count_d     = '0;
					active_d         = 1'b1;
					done_flag_d      = 1'b0;
					clock_level_d    = clock_polarity_q;
				end
			end else if (({1'b0, prescale_count_q} + 7'd1) >= half) begin
				// End of a half period: toggle SCK
				prescale_count_d = '0;
				clock_level_d    = !clock_level_q;
				edge_count_d     = edge_next;
				if (leading == !clock_phase_q) begin
					in_shifter_d = lsb_first_q ? {miso, in_shifter_q[7:1]}
					                           : {in_shifter_q[6:0], miso};
				end
				if ((!clock_phase_q && !leading && (edge_next < LAST_EDGE)) ||
				    (clock_phase_q && leading && (edge_next > 5'd1))) begin
					out_shifter_d = lsb_first_q ? {1'b0, out_shifter_q[7:1]}
					                            : {out_shifter_q[6:0], 1'b0};
				end
				if (edge_next >= LAST_EDGE) begin
					active_d        = 1'b0;
					edge_count_d    = '0;
					received_byte_d = in_shifter_d;
					done_flag_d     = 1'b1;
					clock_level_d   = clock_polarity_q;
				end
			end else begin
				prescale_count_d = prescale_count_q + 6'd1;
			end
		end
		// Flip SCK with a polarity change so the edge sequence is kept
		if (pol_write) begin
			clock_level_d = clock_level_d ^ clock_polarity_q ^ cfg_data[0];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_select_q    <= RATE_RESET;
			double_speed_q   <= 1'b0;
			clock_polarity_q <= 1'b0;
			clock_phase_q    <= 1'b0;
			lsb_first_q      <= 1'b0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_RATE_SELECT:    rate_select_q    <= cfg_data;
				CFG_DOUBLE_SPEED:   double_speed_q   <= cfg_data[0];
				CFG_CLOCK_POLARITY: clock_polarity_q <= cfg_data[0];
				CFG_CLOCK_PHASE:    clock_phase_q    <= cfg_data[0];
				CFG_LSB_FIRST:      lsb_first_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Transfer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_shifter_q    <= '0;
			in_shifter_q     <= '0;
			received_byte_q  <= '0;
			prescale_count_q <= '0;
			edge_count_q     <= '0;
			active_q         <= 1'b0;
			clock_level_q    <= 1'b0;
			done_flag_q      <= 1'b0;
		end else begin
			out_shifter_q    <= out_shifter_d;
			in_shifter_q     <= in_shifter_d;
			received_byte_q  <= received_byte_d;
			prescale_count_q <= prescale_count_d;
			edge_count_q     <= edge_count_d;
			active_q         <= active_d;
			clock_level_q    <= clock_level_d;
			done_flag_q      <= done_flag_d;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the post-tick snapshot
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sck_q  <= clock_level_d;
			mosi_q <= lsb_first_q ? out_shifter_d[0] : out_shifter_d[7];
			busy_q <= active_d;
			done_q <= done_flag_d;
			rx_q   <= received_byte_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign sck           = sck_q;
	assign mosi          = mosi_q;
	assign busy_res      = busy_q;
	assign transfer_done = done_q;
	assign rx_byte       = rx_q;

`ifndef SYNTHESIS
	// Busy and done never show together
	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(busy_q && done_q))
		else $error("busy and done both set in result");

	// Edge count stays below the final edge
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q < LAST_EDGE)
		else $error("edge count out of range");

	// Idle means no edges counted
	a_idle_edges: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (edge_count_q == '0))
		else $error("edge count nonzero while idle");

	// Prescaler rests at zero while idle
	a_prescale_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (prescale_count_q == '0))
		else $error("prescale count nonzero while idle");

	// Every accepted request yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted request produced no result");
`endif

endmodule

### tb/tb_spi_master_byte_shifter.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SPI master byte shifter testbench
// Drives tick requests with random gaps and random result back-pressure.
// Each accepted result is checked, pin by pin, against a cycle-level shifter
// predictor. A short directed table covers reset, the fastest rate, a full
// 0xFF transfer, restarts and register writes during a transfer. Random
// phases follow, each with its own register setting.
// ---------------------------------------------------------------------------
module tb_spi_master_byte_shifter;
	import spi_mbs_pkg::*;

	localparam int IDLE_LIMIT    = 500;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 950;

	// One snapshot of the pins and status
	typedef struct packed {
		logic  sck;
		logic  mosi;
		logic  busy;
		logic  done;
		byte_t rx;
	} pins_t;

	typedef struct {
		rate_t rate;
		logic  dbl;
		logic  cpol;
		logic  cpha;
		logic  lsb;
	} spi_cfg_t;

	typedef struct {
		byte_t       out_sr;
		byte_t       in_sr;
		byte_t       rx_hold;
		int unsigned prescale;
		int unsigned edges;
		logic        active;
		logic        level;
		logic        done;
	} shifter_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic       start;
		byte_t      tx;
		logic       miso;
		cfg_index_t index;
		cfg_data_t  data;
		bit         typed;
		pins_t      want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       start_req = 1'b0;
	logic [7:0] tx_byte = 8'h00;
	logic       miso = 1'b0;
	logic       out_ready = 1'b0;
	logic       cfg_valid = 1'b0;
	cfg_index_t cfg_index = '0;
	cfg_data_t  cfg_data = '0;

	logic       in_ready;
	logic       out_valid;
	logic       sck;
	logic       mosi;
	logic       busy_res;
	logic       transfer_done;
	logic [7:0] rx_byte;
	logic       cfg_ready;

	spi_cfg_t    model_cfg;
	shifter_t    model_sh;
	pins_t       expected_pins[$];
	int unsigned n_issued = 0;
	int unsigned n_checked = 0;
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	bit          steady = 1'b0;

	spi_master_byte_shifter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_req    (start_req),
		.tx_byte      (tx_byte),
		.miso         (miso),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sck          (sck),
		.mosi         (mosi),
		.busy_res     (busy_res),
		.transfer_done(transfer_done),
		.rx_byte      (rx_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Half SCK period in ticks for the current rate setting
	function automatic int unsigned half_ticks();
		int unsigned base;
		case (model_cfg.rate)
			2'd0:    base = 2;
			2'd1:    base = 8;
			2'd2:    base = 32;
			default: base = 64;
		endcase
		return model_cfg.dbl ? (base >> 1) : base;
	endfunction

	// Advance the shifter by one tick and return the pins after it
	function automatic pins_t shift_tick(logic s, byte_t tx, logic m);
		int unsigned e;
		logic        leading;
		pins_t       p;
		if (!model_sh.active) begin
			if (s) begin
				model_sh.out_sr   = tx;
				model_sh.in_sr    = 8'h00;
				model_sh.prescale = 0;
				model_sh.edges    = 0;
				model_sh.active   = 1'b1;
				model_sh.done     = 1'b0;
				model_sh.level    = model_cfg.cpol;
			end
		end else if (model_sh.prescale + 1 >= half_ticks()) begin
			model_sh.prescale = 0;
			model_sh.level    = ~model_sh.level;
			model_sh.edges    = (model_sh.edges + 1) & 31;
			e       = model_sh.edges;
			leading = (e & 1) != 0;
			// sample on the edge the phase selects
			if (leading == !model_cfg.cpha) begin
				if (model_cfg.lsb)
					model_sh.in_sr = {m, model_sh.in_sr[7:1]};
				else
					model_sh.in_sr = {model_sh.in_sr[6:0], m};
			end
			// shift out on the opposite edge, never past the last bit
			if ((!model_cfg.cpha && !leading && e < 16) ||
			    (model_cfg.cpha && leading && e > 1)) begin
				if (model_cfg.lsb)
					model_sh.out_sr = model_sh.out_sr >> 1;
				else
					model_sh.out_sr = model_sh.out_sr << 1;
			end
			if (e >= 16) begin
				model_sh.active  = 1'b0;
				model_sh.edges   = 0;
				model_sh.rx_hold = model_sh.in_sr;
				model_sh.done    = 1'b1;
				model_sh.level   = model_cfg.cpol;
			end
		end else begin
			model_sh.prescale = (model_sh.prescale + 1) & 63;
		end
		p.sck  = model_sh.level;
		p.mosi = model_cfg.lsb ? model_sh.out_sr[0] : model_sh.out_sr[7];
		p.busy = model_sh.active;
		p.done = model_sh.done;
		p.rx   = model_sh.rx_hold;
		return p;
	endfunction

	// Mirror a register write into the predictor
	function automatic void apply_cfg(cfg_index_t idx, cfg_data_t d);
		case (idx)
			CFG_RATE_SELECT:    model_cfg.rate = d;
			CFG_DOUBLE_SPEED:   model_cfg.dbl  = d[0];
			CFG_CLOCK_POLARITY: begin
				// keep the edge sequence: flip the level along with polarity
				model_sh.level = model_sh.level ^ model_cfg.cpol ^ d[0];
				model_cfg.cpol = d[0];
			end
			CFG_CLOCK_PHASE:    model_cfg.cpha = d[0];
			CFG_LSB_FIRST:      model_cfg.lsb  = d[0];
			default: ;
		endcase
	endfunction

	function automatic stim_row_t tick_row(logic s, byte_t tx, logic m, bit typed, pins_t want);
		stim_row_t r;
		r       = '{kind: ROW_TICK, default: '0};
		r.kind  = ROW_TICK;
		r.start = s;
		r.tx    = tx;
		r.miso  = m;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(cfg_index_t idx, cfg_data_t d);
		stim_row_t r;
		r       = '{kind: ROW_CFG, default: '0};
		r.kind  = ROW_CFG;
		r.index = idx;
		r.data  = d;
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Send one tick request after a random gap, predict at acceptance
	task automatic send_tick(logic s, byte_t tx, logic m, bit typed, pins_t want);
		int    gap;
		pins_t p;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		start_req <= s;
		tx_byte   <= tx;
		miso      <= m;
		do @(posedge clk); while (!in_ready);
		p = shift_tick(s, tx, m);
		expected_pins.push_back(typed ? want : p);
		n_issued++;
	endtask

	// Hold requests until every expected result is back, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		wait (n_checked == n_issued);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Raise a register write; the caller drops cfg_valid after the last one
	task automatic write_reg(cfg_index_t idx, cfg_data_t d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, d);
	endtask

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		pins_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pins.size() == 0) begin
				$error("result with no request waiting: sck %0b mosi %0b rx %0h",
				       sck, mosi, rx_byte);
				errors++;
			end else begin
				want = expected_pins.pop_front();
				check_field("sck", 8'(want.sck), 8'(sck));
				check_field("mosi", 8'(want.mosi), 8'(mosi));
				check_field("busy_res", 8'(want.busy), 8'(busy_res));
				check_field("transfer_done", 8'(want.done), 8'(transfer_done));
				check_field("rx_byte", want.rx, rx_byte);
				n_checked++;
			end
		end
	end

	// Stall the result side for a random number of cycles per result
	always @(posedge clk) begin : result_stall
		int unsigned w;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (out_ready && out_valid) begin
			w = steady ? 0 : $urandom_range(0, 3);
			stall_left <= w;
			out_ready  <= (w == 0);
		end else if (!out_ready) begin
			if (stall_left <= 1) begin
				out_ready  <= 1'b1;
				stall_left <= 0;
			end else begin
				stall_left <= stall_left - 1;
			end
		end
	end

	// Abort when no channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		stim_row_t   rows[$];
		stim_row_t   r;
		int unsigned count;
		int unsigned phase;
		int unsigned len;
		rate_t       rate;
		logic        dbl;
		logic [2:0]  modes;
		cfg_data_t   d;
		logic        s;

		model_cfg = '{RATE_RESET, 1'b0, 1'b0, 1'b0, 1'b0};
		model_sh  = '{8'h00, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0, 1'b0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset pins, fastest rate, full 0xFF transfer, restarts
		rows.push_back(tick_row(1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}));
		rows.push_back(cfg_row(cfg_index_t'(3'd7), cfg_data_t'(2'd3)));
		rows.push_back(cfg_row(CFG_RATE_SELECT, cfg_data_t'(2'd0)));
		rows.push_back(cfg_row(CFG_DOUBLE_SPEED, cfg_data_t'(2'd1)));
		rows.push_back(tick_row(1'b1, 8'hFF, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00}));
		for (int i = 0; i < 16; i++)
			rows.push_back(tick_row(1'b0, 8'h00, 1'b1, 1'b0, '0));
		rows.push_back(tick_row(1'b1, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF}));
		// start while busy is dropped
		rows.push_back(tick_row(1'b1, 8'h5A, 1'b0, 1'b0, '0));
		// polarity, order and phase changed in the middle of a transfer
		rows.push_back(cfg_row(CFG_CLOCK_POLARITY, cfg_data_t'(2'd3)));
		rows.push_back(tick_row(1'b0, 8'h00, 1'b1, 1'b0, '0));
		rows.push_back(cfg_row(CFG_LSB_FIRST, cfg_data_t'(2'd1)));
		rows.push_back(cfg_row(CFG_CLOCK_PHASE, cfg_data_t'(2'd1)));
		rows.push_back(tick_row(1'b0, 8'h00, 1'b0, 1'b0, '0));
		rows.push_back(tick_row(1'b0, 8'h00, 1'b1, 1'b0, '0));

		for (int i = 0; i < rows.size(); i++) begin
			r = rows[i];
			if (r.kind == ROW_CFG) begin
				settle();
				write_reg(r.index, r.data);
				cfg_valid <= 1'b0;
			end else begin
				send_tick(r.start, r.tx, r.miso, r.typed, r.want);
			end
		end

		// Random phases, each under its own register setting
		count = 0;
		phase = 0;
		while (count < RANDOM_ITEMS) begin
			settle();
			steady = (phase % 4 == 3);
			modes  = 3'($urandom_range(0, 7));
			len    = 60;
			if (phase < 8) begin
				// every mode and order at the fastest rate
				rate  = 2'd0;
				dbl   = 1'b1;
				modes = phase[2:0];
				len   = 50;
			end else if (phase == 8) begin
				rate = 2'd3;
				dbl  = 1'b0;
				len  = 200;
			end else if (phase == 9) begin
				// slow count left running meets a short half period
				rate = 2'd0;
				dbl  = 1'b0;
				len  = 50;
			end else if (phase == 10) begin
				rate = 2'd3;
				dbl  = 1'b1;
				len  = 80;
			end else begin
				rate = ($urandom_range(0, 3) == 0) ? rate_t'($urandom_range(0, 3))
				                                   : rate_t'($urandom_range(0, 1));
				dbl  = 1'($urandom_range(0, 1));
			end

			write_reg(CFG_RATE_SELECT, rate);
			d = cfg_data_t'($urandom_range(0, 3));
			d[0] = dbl;
			write_reg(CFG_DOUBLE_SPEED, d);
			d = cfg_data_t'($urandom_range(0, 3));
			d[0] = modes[0];
			write_reg(CFG_CLOCK_POLARITY, d);
			d = cfg_data_t'($urandom_range(0, 3));
			d[0] = modes[1];
			write_reg(CFG_CLOCK_PHASE, d);
			d = cfg_data_t'($urandom_range(0, 3));
			d[0] = modes[2];
			write_reg(CFG_LSB_FIRST, d);
			if ($urandom_range(0, 3) == 0)
				write_reg(cfg_index_t'($urandom_range(5, 7)), cfg_data_t'($urandom_range(0, 3)));
			cfg_valid <= 1'b0;

			// start often when idle, rarely while a transfer runs
			repeat (len) begin
				if (!model_sh.active)
					s = ($urandom_range(0, 3) != 0);
				else
					s = ($urandom_range(0, 7) == 0);
				send_tick(s, byte_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)),
				          1'b0, '0);
				count++;
			end
			phase++;
		end

		settle();
		if (errors == 0 && expected_pins.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
